[rtl/sbda_pkg.sv]
// shared constants and state codes for the signed binary to decimal ascii converter
`default_nettype none

package sbda_pkg;

    localparam int MagW  = 64;
    localparam int DigN  = 20;
    localparam int BcdW  = 4 * DigN;
    localparam int BitCntW = $clog2(MagW);
    localparam int DigCntW = $clog2(DigN + 1);

    localparam logic [7:0] CharZero  = 8'd48;
    localparam logic [7:0] CharMinus = 8'd45;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_TRIM = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

endpackage

`default_nettype wire

[rtl/sbda_if.sv]
// request channels: signed integer in, ascii character out
`default_nettype none

interface sbda_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

[rtl/sbda_dabble.sv]
// one shift-and-add-3 step over the whole bcd register
`default_nettype none

module sbda_dabble (
    input  wire logic [sbda_pkg::BcdW-1:0] i_bcd,
    input  wire logic                      i_bit,
    output logic      [sbda_pkg::BcdW-1:0] o_bcd
);

    logic [sbda_pkg::BcdW-1:0] adj;

    always_comb begin
        for (int d = 0; d < sbda_pkg::DigN; d++) begin
            if (i_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = i_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = i_bcd[4*d +: 4];
            end
        end
    end

    assign o_bcd = {adj[sbda_pkg::BcdW-2:0], i_bit};

endmodule

`default_nettype wire

[rtl/signed_binary_to_decimal_ascii.sv]
// signed 64-bit integer to decimal ascii text, one character per output request
//
// input channel i_in carries one signed 64-bit value per request; output
// channel o_out carries one ascii character per request, most significant
// first, with last_char set on the final one. negative values start with
// '-'; zero gives a single '0'; no leading zeros; at most 20 characters.
// the magnitude is converted by a shared shift-and-add-3 step, one magnitude
// bit per cycle. leading zero digits are then dropped one per cycle (up to
// 19 of them), then one character is emitted per cycle while the receiver
// takes them. i_in.ready is high only while the sequencer is idle; the last
// character may still wait in the output register while the next value is
// accepted. a stall on o_out holds the sequencer in its sign or emit state
// with the character held steady. synchronous reset returns to idle and
// empties the output register.
`default_nettype none

module signed_binary_to_decimal_ascii (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbda_in_if.sink    i_in,
    sbda_out_if.source o_out
);

    logic [2:0]                         r_state, n_state;
    logic [sbda_pkg::MagW-1:0]          r_mag, n_mag;
    logic [sbda_pkg::BcdW-1:0]          r_bcd, n_bcd;
    logic [sbda_pkg::BitCntW-1:0]       r_bit_cnt, n_bit_cnt;
    logic [sbda_pkg::DigCntW-1:0]       r_dig_cnt, n_dig_cnt;
    logic                               r_neg, n_neg;
    logic                               r_oval, n_oval;
    logic [7:0]                         r_char, n_char;
    logic                               r_last, n_last;

    logic [sbda_pkg::BcdW-1:0]          step_bcd;
    logic                               out_free;
    logic [3:0]                         top_dig;

    sbda_dabble u_dabble (
        .i_bcd (r_bcd),
        .i_bit (r_mag[sbda_pkg::MagW-1]),
        .o_bcd (step_bcd)
    );

    assign out_free        = !r_oval || o_out.ready;
    assign top_dig         = r_bcd[sbda_pkg::BcdW-1 -: 4];
    assign i_in.ready      = (r_state == sbda_pkg::ST_IDLE);
    assign o_out.valid     = r_oval;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_bcd     = r_bcd;
        n_bit_cnt = r_bit_cnt;
        n_dig_cnt = r_dig_cnt;
        n_neg     = r_neg;
        n_oval    = r_oval;
        n_char    = r_char;
        n_last    = r_last;

        if (r_oval && o_out.ready) begin
            n_oval = 1'b0;
        end

        case (r_state)
            sbda_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_neg     = i_in.value[sbda_pkg::MagW-1];
                    n_mag     = i_in.value[sbda_pkg::MagW-1] ? 64'd0 - i_in.value
                                                             : i_in.value;
                    n_bcd     = '0;
                    n_bit_cnt = '0;
                    n_dig_cnt = sbda_pkg::DigCntW'(sbda_pkg::DigN);
                    n_state   = sbda_pkg::ST_CONV;
                end
            end
            sbda_pkg::ST_CONV: begin
                n_bcd     = step_bcd;
                n_mag     = {r_mag[sbda_pkg::MagW-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt + 1'b1;
                if (r_bit_cnt == sbda_pkg::BitCntW'(sbda_pkg::MagW - 1)) begin
                    n_state = sbda_pkg::ST_TRIM;
                end
            end
            sbda_pkg::ST_TRIM: begin
                if (top_dig == 4'd0 && r_dig_cnt != sbda_pkg::DigCntW'(1)) begin
                    n_bcd     = {r_bcd[sbda_pkg::BcdW-5:0], 4'd0};
                    n_dig_cnt = r_dig_cnt - 1'b1;
                end else if (r_neg) begin
                    n_state = sbda_pkg::ST_SIGN;
                end else begin
                    n_state = sbda_pkg::ST_EMIT;
                end
            end
            sbda_pkg::ST_SIGN: begin
                if (out_free) begin
                    n_oval  = 1'b1;
                    n_char  = sbda_pkg::CharMinus;
                    n_last  = 1'b0;
                    n_state = sbda_pkg::ST_EMIT;
                end
            end
            sbda_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_oval    = 1'b1;
                    n_char    = sbda_pkg::CharZero + {4'd0, top_dig};
                    n_last    = (r_dig_cnt == sbda_pkg::DigCntW'(1));
                    n_bcd     = {r_bcd[sbda_pkg::BcdW-5:0], 4'd0};
                    n_dig_cnt = r_dig_cnt - 1'b1;
                    if (r_dig_cnt == sbda_pkg::DigCntW'(1)) begin
                        n_state = sbda_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sbda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbda_pkg::ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_bcd     <= n_bcd;
        r_bit_cnt <= n_bit_cnt;
        r_dig_cnt <= n_dig_cnt;
        r_neg     <= n_neg;
        r_char    <= n_char;
        r_last    <= n_last;
    end

endmodule

`default_nettype wire
